FILE: hdl/hbw_pkg.sv
// Shared types, constants and the init sequence table for the LCD backpack writer.
`default_nettype none

package hbw_pkg;

    // Input command codes
    localparam logic [2:0] CMD_INIT        = 3'd0;
    localparam logic [2:0] CMD_CLEAR       = 3'd1;
    localparam logic [2:0] CMD_CURSOR      = 3'd2;
    localparam logic [2:0] CMD_CHAR        = 3'd3;
    localparam logic [2:0] CMD_LIGHT       = 3'd4;
    localparam logic [2:0] CMD_GLYPH_START = 3'd5;
    localparam logic [2:0] CMD_GLYPH_ROW   = 3'd6;

    // HD44780 instruction bytes
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
    localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [3:0] LCD_WAKE_NIB  = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB  = 4'h2;

    // Cursor clamps
    localparam logic [7:0] ROW_MAX = 8'd3;
    localparam logic [7:0] COL_MAX = 8'd19;

    // Init sequence timing
    localparam logic [5:0] POWER_ON_MS = 6'd50;
    localparam logic [4:0] INIT_LAST   = 5'd25;
    localparam logic [4:0] BYTE_LAST   = 5'd3;
    localparam logic [4:0] HOME_LAST   = 5'd7;
    localparam logic [2:0] GLYPH_ROWS_LAST = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] row;
        logic [7:0] column;
        logic [7:0] data_byte;
        logic       light_on;
        logic [7:0] glyph_slot;
    } t_in_item;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       do_write;
        logic [5:0] wait_ms;
        logic       last;
    } t_out_item;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        JOB_BYTE,       // one LCD byte, four expander beats
        JOB_BYTE_HOME,  // LCD byte then set-DDRAM 0x80, eight beats
        JOB_SINGLE,     // one backlight-only beat
        JOB_INIT        // full power-up sequence, 26 beats
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] value;
        logic       rs;
        logic [1:0] extra;
        logic       bl;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_beat;

    typedef struct packed {
        logic [3:0] nib;
        logic [2:0] extra;
    } t_init_nib;

    // DDRAM row start addresses
    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    // Nibbles of the init sequence with their extra delay
    function automatic t_init_nib init_nibble(input logic [3:0] k);
        t_init_nib e;
        case (k)
            4'd0:    e = '{nib: LCD_WAKE_NIB,        extra: 3'd5};
            4'd1:    e = '{nib: LCD_WAKE_NIB,        extra: 3'd1};
            4'd2:    e = '{nib: LCD_WAKE_NIB,        extra: 3'd1};
            4'd3:    e = '{nib: LCD_4BIT_NIB,        extra: 3'd1};
            4'd4:    e = '{nib: LCD_FUNC_4BIT[7:4],  extra: 3'd0};
            4'd5:    e = '{nib: LCD_FUNC_4BIT[3:0],  extra: 3'd1};
            4'd6:    e = '{nib: LCD_DISP_ON[7:4],    extra: 3'd0};
            4'd7:    e = '{nib: LCD_DISP_ON[3:0],    extra: 3'd1};
            4'd8:    e = '{nib: LCD_CLEAR[7:4],      extra: 3'd0};
            4'd9:    e = '{nib: LCD_CLEAR[3:0],      extra: 3'd2};
            4'd10:   e = '{nib: LCD_ENTRY[7:4],      extra: 3'd0};
            4'd11:   e = '{nib: LCD_ENTRY[3:0],      extra: 3'd1};
            default: e = '{nib: 4'h0,                extra: 3'd0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hbw_front.sv
// Front end: accepts commands, tracks backlight and glyph state, queues jobs.
`default_nettype none

module hbw_front
    import hbw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    input  wire logic      i_full,
    output t_job_beat      o_push
);

    logic       r_backlight, n_backlight;
    logic       r_glyph_active, n_glyph_active;
    logic [2:0] r_glyph_rows, n_glyph_rows;

    logic       accept;
    logic [1:0] row_c;
    logic [4:0] col_c;
    logic [7:0] addr_sum;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Cursor address with clamped row and column
    always_comb begin
        row_c    = (i_item.row > ROW_MAX) ? ROW_MAX[1:0] : i_item.row[1:0];
        col_c    = (i_item.column > COL_MAX) ? COL_MAX[4:0] : i_item.column[4:0];
        addr_sum = row_base(row_c) + {3'b000, col_c};
    end

    // Classify the command into a job and the next state
    always_comb begin
        n_backlight    = r_backlight;
        n_glyph_active = r_glyph_active;
        n_glyph_rows   = r_glyph_rows;
        o_push.valid      = 1'b0;
        o_push.job.kind   = JOB_BYTE;
        o_push.job.value  = i_item.data_byte;
        o_push.job.rs     = 1'b0;
        o_push.job.extra  = 2'd0;
        o_push.job.bl     = r_backlight;
        case (i_item.command)
            CMD_INIT: begin
                n_backlight     = 1'b1;
                n_glyph_active  = 1'b0;
                n_glyph_rows    = 3'd0;
                o_push.valid    = 1'b1;
                o_push.job.kind = JOB_INIT;
                o_push.job.bl   = 1'b1;
            end
            CMD_CLEAR: begin
                n_glyph_active   = 1'b0;
                n_glyph_rows     = 3'd0;
                o_push.valid     = 1'b1;
                o_push.job.value = LCD_CLEAR;
                o_push.job.extra = 2'd2;
            end
            CMD_CURSOR: begin
                n_glyph_active   = 1'b0;
                n_glyph_rows     = 3'd0;
                o_push.valid     = 1'b1;
                o_push.job.value = LCD_SET_DDRAM | {1'b0, addr_sum[6:0]};
            end
            CMD_CHAR: begin
                o_push.valid  = 1'b1;
                o_push.job.rs = 1'b1;
            end
            CMD_LIGHT: begin
                n_backlight     = i_item.light_on;
                o_push.valid    = 1'b1;
                o_push.job.kind = JOB_SINGLE;
                o_push.job.bl   = i_item.light_on;
            end
            CMD_GLYPH_START: begin
                if (i_item.glyph_slot <= 8'd7) begin
                    n_glyph_active   = 1'b1;
                    n_glyph_rows     = 3'd0;
                    o_push.valid     = 1'b1;
                    o_push.job.value = LCD_SET_CGRAM | {2'b00, i_item.glyph_slot[2:0], 3'b000};
                end
            end
            CMD_GLYPH_ROW: begin
                if (r_glyph_active) begin
                    o_push.valid  = 1'b1;
                    o_push.job.rs = 1'b1;
                    if (r_glyph_rows == GLYPH_ROWS_LAST) begin
                        o_push.job.kind = JOB_BYTE_HOME;
                        n_glyph_active  = 1'b0;
                        n_glyph_rows    = 3'd0;
                    end else begin
                        n_glyph_rows = r_glyph_rows + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!accept) begin
            o_push.valid = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight    <= 1'b1;
            r_glyph_active <= 1'b0;
            r_glyph_rows   <= 3'd0;
        end else if (accept) begin
            r_backlight    <= n_backlight;
            r_glyph_active <= n_glyph_active;
            r_glyph_rows   <= n_glyph_rows;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbw_queue.sv
// Small job queue between the front and back ends.
`default_nettype none

module hbw_queue
    import hbw_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job_beat  i_push,
    output logic            o_full,
    output t_job_beat       o_head,
    input  wire logic       i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;
    assign o_full  = (r_count == CW'(DEPTH));

    // Head of queue
    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.job   = r_mem[r_rd];
    end

    // Pointer wrap
    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbw_back.sv
// Back end: expands queued jobs into expander beats, one per cycle while the output is taken.
`default_nettype none

module hbw_back
    import hbw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_beat i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic [4:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;

    t_job       job;
    logic       advance;
    logic       is_last;
    logic [4:0] last_step;
    logic [4:0] init_idx;
    t_init_nib  init_e;
    logic       home_sel;
    logic [7:0] val;
    logic       rs;
    logic [3:0] nib;
    logic       en;
    logic [2:0] ext;
    t_out_item  beat;

    assign job     = i_head.job;
    assign advance = i_head.valid && (!r_out_valid || i_ready);
    assign is_last = (r_step == last_step);
    assign o_pop   = advance && is_last;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Build the beat for the current step of the head job
    always_comb begin
        init_idx = r_step - 5'd1;
        init_e   = init_nibble(init_idx[4:1]);
        home_sel = (job.kind == JOB_BYTE_HOME) && r_step[2];
        val      = home_sel ? LCD_SET_DDRAM : job.value;
        rs       = home_sel ? 1'b0 : job.rs;
        nib      = r_step[1] ? val[3:0] : val[7:4];
        en       = !r_step[0];
        ext      = (r_step[1:0] == 2'd3) ? {1'b0, job.extra} : 3'd0;
        last_step = BYTE_LAST;
        beat.expander_byte = {nib, job.bl, en, 1'b0, rs};
        beat.do_write      = 1'b1;
        beat.wait_ms       = en ? 6'd1 : 6'd1 + {3'b000, ext};
        beat.last          = 1'b0;
        case (job.kind)
            JOB_BYTE: begin
                last_step = BYTE_LAST;
            end
            JOB_BYTE_HOME: begin
                last_step = HOME_LAST;
            end
            JOB_SINGLE: begin
                last_step          = 5'd0;
                beat.expander_byte = {4'h0, job.bl, 3'b000};
                beat.wait_ms       = 6'd0;
            end
            JOB_INIT: begin
                last_step = INIT_LAST;
                if (r_step == 5'd0) begin
                    beat.expander_byte = 8'h00;
                    beat.do_write      = 1'b0;
                    beat.wait_ms       = POWER_ON_MS;
                end else if (r_step == INIT_LAST) begin
                    beat.expander_byte = {4'h0, job.bl, 3'b000};
                    beat.wait_ms       = 6'd0;
                end else begin
                    beat.expander_byte = {init_e.nib, job.bl, !init_idx[0], 2'b00};
                    beat.wait_ms       = !init_idx[0] ? 6'd1 : 6'd1 + {3'b000, init_e.extra};
                end
            end
            default: begin
                last_step = BYTE_LAST;
            end
        endcase
        beat.last = (r_step == last_step);
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= beat;
        end
    end

    // Step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step      <= is_last ? 5'd0 : r_step + 5'd1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A job in progress never runs past its final step
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_step <= last_step))
        else $error("step counter past end of job");

    // A nonzero step means a job is still at the queue head
    a_step_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 5'd0) |-> i_head.valid)
        else $error("step counter running without a job");

    // The job is popped exactly on the beat flagged last
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_item.last))
        else $error("job popped without a last beat");

endmodule

`default_nettype wire

FILE: hdl/hd44780_i2c_backpack_writer.sv
// Top level: HD44780 4-bit command stream to PCF8574 expander bytes.
`default_nettype none

// Each accepted command yields its expander beats one per cycle while the output
// is taken every cycle: init 26 beats, clear, cursor set, character, glyph start
// and a normal glyph row 4 beats, the eighth glyph row 8 beats, backlight 1 beat;
// ignored commands produce nothing. The single beat generator in the back end
// sets the rate. Commands are taken whenever the job queue (QUEUE_DEPTH entries)
// has room, so the input side runs ahead of a stalled output by up to the queue
// depth plus the beat being shown.
module hd44780_i2c_backpack_writer
    import hbw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);

    t_job_beat push;
    t_job_beat head;
    logic      full;
    logic      pop;

    hbw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push)
    );

    hbw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    hbw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the HD44780 expander byte writer: random commands in, beats checked.
`default_nettype none

module tb;
    import hbw_pkg::*;

    // Command code with no meaning; the block must drop it silently
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // DDRAM start address of each display row
    localparam logic [3:0][7:0] ROW_START = {8'h54, 8'h14, 8'h40, 8'h00};

    // Idle percentages per phase: sender busy / receiver slow, then swapped, then none
    localparam logic [2:0][6:0] SEND_IDLE = {7'd0, 7'd76, 7'd6};
    localparam logic [2:0][6:0] RECV_IDLE = {7'd0, 7'd6, 7'd76};

    localparam int RANDOM_CMDS = 395;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 600000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    // Commands waiting to be driven, beats the display side still owes us
    t_in_item  lcd_cmds[$];
    t_out_item due_beats[$];

    // Shadow of the block's state
    logic       model_backlight = 1'b1;
    logic       model_glyph_on = 1'b0;
    logic [2:0] model_glyph_rows = 3'd0;

    int         cmds_total = 1;
    int         cmds_taken = 0;
    logic [1:0] idle_phase = 2'd0;
    int         errors = 0;
    int         cycles = 0;

    hd44780_i2c_backpack_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // Expected beat builders
    task automatic push_beat(input logic [7:0] val, input logic wr, input logic [5:0] wait_ms);
        t_out_item b;
        b.expander_byte = val;
        b.do_write = wr;
        b.wait_ms = wait_ms;
        b.last = 1'b0;
        due_beats.push_back(b);
    endtask

    // One nibble: enable-high strobe, then enable-low carrying the extra delay
    task automatic push_nibble(input logic [7:0] hi, input logic rs, input logic [5:0] extra);
        push_beat({hi[7:4], model_backlight, 1'b1, 1'b0, rs}, 1'b1, 6'd1);
        push_beat({hi[7:4], model_backlight, 1'b0, 1'b0, rs}, 1'b1, 6'd1 + extra);
    endtask

    task automatic push_lcd_byte(input logic [7:0] val, input logic rs, input logic [5:0] extra);
        push_nibble(val, rs, 6'd0);
        push_nibble({val[3:0], 4'h0}, rs, extra);
    endtask

    // Work out the beats one accepted command causes and update the shadow state
    task automatic predict_beats(input t_in_item it);
        int         prev_size;
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] addr;
        t_out_item  b;
        prev_size = due_beats.size();
        case (it.command)
            CMD_INIT: begin
                model_backlight = 1'b1;
                model_glyph_on = 1'b0;
                model_glyph_rows = 3'd0;
                push_beat(8'h00, 1'b0, POWER_ON_MS);
                push_nibble({LCD_WAKE_NIB, 4'h0}, 1'b0, 6'd5);
                push_nibble({LCD_WAKE_NIB, 4'h0}, 1'b0, 6'd1);
                push_nibble({LCD_WAKE_NIB, 4'h0}, 1'b0, 6'd1);
                push_nibble({LCD_4BIT_NIB, 4'h0}, 1'b0, 6'd1);
                push_lcd_byte(LCD_FUNC_4BIT, 1'b0, 6'd1);
                push_lcd_byte(LCD_DISP_ON, 1'b0, 6'd1);
                push_lcd_byte(LCD_CLEAR, 1'b0, 6'd2);
                push_lcd_byte(LCD_ENTRY, 1'b0, 6'd1);
                push_beat({4'h0, model_backlight, 3'b000}, 1'b1, 6'd0);
            end
            CMD_CLEAR: begin
                model_glyph_on = 1'b0;
                model_glyph_rows = 3'd0;
                push_lcd_byte(LCD_CLEAR, 1'b0, 6'd2);
            end
            CMD_CURSOR: begin
                r = (it.row > ROW_MAX) ? ROW_MAX : it.row;
                c = (it.column > COL_MAX) ? COL_MAX : it.column;
                addr = ROW_START[r[1:0]] + c;
                model_glyph_on = 1'b0;
                model_glyph_rows = 3'd0;
                push_lcd_byte(LCD_SET_DDRAM | {1'b0, addr[6:0]}, 1'b0, 6'd0);
            end
            CMD_CHAR: push_lcd_byte(it.data_byte, 1'b1, 6'd0);
            CMD_LIGHT: begin
                model_backlight = it.light_on;
                push_beat({4'h0, model_backlight, 3'b000}, 1'b1, 6'd0);
            end
            CMD_GLYPH_START: begin
                // slots above 7 are dropped without touching state
                if (it.glyph_slot <= 8'd7) begin
                    push_lcd_byte(LCD_SET_CGRAM | {2'b00, it.glyph_slot[2:0], 3'b000},
                                  1'b0, 6'd0);
                    model_glyph_on = 1'b1;
                    model_glyph_rows = 3'd0;
                end
            end
            CMD_GLYPH_ROW: begin
                if (model_glyph_on) begin
                    push_lcd_byte(it.data_byte, 1'b1, 6'd0);
                    // eighth row sends the controller back to DDRAM address 0
                    if (model_glyph_rows >= GLYPH_ROWS_LAST) begin
                        push_lcd_byte(LCD_SET_DDRAM, 1'b0, 6'd0);
                        model_glyph_on = 1'b0;
                        model_glyph_rows = 3'd0;
                    end else begin
                        model_glyph_rows = model_glyph_rows + 3'd1;
                    end
                end
            end
            default: ;
        endcase
        if (due_beats.size() > prev_size) begin
            b = due_beats.pop_back();
            b.last = 1'b1;
            due_beats.push_back(b);
        end
    endtask

    // Command with every field random, then the caller overrides what matters
    function automatic t_in_item rand_cmd(input logic [2:0] cmd);
        t_in_item it;
        it.command = cmd;
        it.row = 8'($urandom);
        it.column = 8'($urandom);
        it.data_byte = 8'($urandom);
        it.light_on = 1'($urandom_range(0, 1));
        it.glyph_slot = 8'($urandom);
        return it;
    endfunction

    // Driver: one command per handshake, random gaps per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_beats(i_item);
                cmds_taken = cmds_taken + 1;
                idle_phase <= (cmds_taken * 3 / cmds_total > 2) ? 2'd2
                                                                : 2'(cmds_taken * 3 / cmds_total);
            end
            if (!i_valid || o_ready) begin
                if (lcd_cmds.size() > 0 && $urandom_range(0, 99) >= SEND_IDLE[idle_phase]) begin
                    i_item <= lcd_cmds.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each beat taken against the oldest expected one
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_beats.size() == 0) begin
                    $display("%0t: unexpected beat, got %h", $time, o_item);
                    errors = errors + 1;
                end else begin
                    want = due_beats.pop_front();
                    if (o_item.expander_byte !== want.expander_byte) begin
                        $display("%0t: expander_byte expected %h got %h",
                                 $time, want.expander_byte, o_item.expander_byte);
                        errors = errors + 1;
                    end
                    if (o_item.do_write !== want.do_write) begin
                        $display("%0t: do_write expected %b got %b",
                                 $time, want.do_write, o_item.do_write);
                        errors = errors + 1;
                    end
                    if (o_item.wait_ms !== want.wait_ms) begin
                        $display("%0t: wait_ms expected %0d got %0d",
                                 $time, want.wait_ms, o_item.wait_ms);
                        errors = errors + 1;
                    end
                    if (o_item.last !== want.last) begin
                        $display("%0t: last expected %b got %b",
                                 $time, want.last, o_item.last);
                        errors = errors + 1;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_phase]);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int       counted;
        int       rows;
        int       pick;

        // Directed: ignored codes first, while no glyph is open
        lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));
        lcd_cmds.push_back(rand_cmd(CMD_UNUSED));
        lcd_cmds.push_back(rand_cmd(CMD_INIT));
        it = rand_cmd(CMD_LIGHT);
        it.light_on = 1'b0;
        lcd_cmds.push_back(it);
        it = rand_cmd(CMD_CHAR);
        it.data_byte = 8'hFF;
        lcd_cmds.push_back(it);
        it = rand_cmd(CMD_LIGHT);
        it.light_on = 1'b1;
        lcd_cmds.push_back(it);
        lcd_cmds.push_back(rand_cmd(CMD_CLEAR));
        // cursor corners, with and without clamping
        it = rand_cmd(CMD_CURSOR);
        it.row = 8'd0;
        it.column = 8'd0;
        lcd_cmds.push_back(it);
        it.row = 8'hFF;
        it.column = 8'hFF;
        lcd_cmds.push_back(it);
        it = rand_cmd(CMD_CHAR);
        it.data_byte = 8'h00;
        lcd_cmds.push_back(it);
        // out-of-range slot is dropped
        it = rand_cmd(CMD_GLYPH_START);
        it.glyph_slot = 8'd8;
        lcd_cmds.push_back(it);
        // glyph restarted mid-way, then a full eight rows
        it.glyph_slot = 8'd3;
        lcd_cmds.push_back(it);
        lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));
        it.glyph_slot = 8'd7;
        lcd_cmds.push_back(it);
        repeat (8) lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));
        // clear cancels an open glyph, so the row after it is dropped
        it.glyph_slot = 8'd0;
        lcd_cmds.push_back(it);
        lcd_cmds.push_back(rand_cmd(CMD_CLEAR));
        lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));

        // Random mix, mostly well-formed glyph uploads among display traffic
        counted = 0;
        while (counted < RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                lcd_cmds.push_back(rand_cmd(CMD_INIT));
                counted++;
            end else if (pick < 10) begin
                lcd_cmds.push_back(rand_cmd(CMD_CLEAR));
                counted++;
            end else if (pick < 22) begin
                it = rand_cmd(CMD_CURSOR);
                if ($urandom_range(0, 1) == 0) begin
                    it.row = 8'($urandom_range(0, 3));
                    it.column = 8'($urandom_range(0, 19));
                end
                lcd_cmds.push_back(it);
                counted++;
            end else if (pick < 45) begin
                lcd_cmds.push_back(rand_cmd(CMD_CHAR));
                counted++;
            end else if (pick < 53) begin
                lcd_cmds.push_back(rand_cmd(CMD_LIGHT));
                counted++;
            end else if (pick < 76) begin
                // glyph upload, usually complete, sometimes cut short
                it = rand_cmd(CMD_GLYPH_START);
                it.glyph_slot = 8'($urandom_range(0, 7));
                lcd_cmds.push_back(it);
                rows = ($urandom_range(0, 4) != 0) ? 8 : $urandom_range(0, 7);
                repeat (rows) lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));
                counted += 1 + rows;
            end else if (pick < 84) begin
                it = rand_cmd(CMD_GLYPH_START);
                it.glyph_slot = 8'($urandom_range(8, 255));
                lcd_cmds.push_back(it);
            end else if (pick < 94) begin
                lcd_cmds.push_back(rand_cmd(CMD_GLYPH_ROW));
            end else begin
                lcd_cmds.push_back(rand_cmd(CMD_UNUSED));
            end
        end
        cmds_total = lcd_cmds.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last command to be taken and every beat to come back
        while (lcd_cmds.size() != 0 || i_valid || due_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
